[design/atti_pkg.sv]
`default_nettype none

package atti_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 16;
    localparam int ADC_BITS    = 12;
    localparam int TEMP_W      = 16;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W     = ADC_BITS + TEMP_W;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int CFG_DATA_W  = 12;

    // Interpolation arithmetic: temp * adc difference, two products summed
    localparam int DIFF_W = ADC_BITS + 1;
    localparam int PROD_W = TEMP_W + DIFF_W;
    localparam int NUM_W  = TEMP_W + ADC_BITS + 2;
    localparam int MAG_W  = NUM_W - 1;

    // Configuration register indexes
    localparam logic CFG_ADC_TOLERANCE  = 1'b0;
    localparam logic CFG_ENTRIES_IN_USE = 1'b1;

    // Operation codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OPEN  = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    // Request to the bit-serial divider
    typedef struct packed {
        logic                start;
        logic [MAG_W-1:0]    dividend;
        logic [ADC_BITS-1:0] divisor;
    } div_req_t;

    // Response from the bit-serial divider
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

[design/adc_temperature_table_interpolator_core.sv]
`default_nettype none

// Load transactions: one per cycle while no convert holds the input, no result, input never stalled by a load.
// Convert transactions end in an open or low clamp result after the first entry, a short or
// high clamp result after the last entry, or an interpolation after a table scan of
// k = 1 .. entries-1 steps and a wait on the bit-serial divider;
// input is stalled until the result is in the output register, so one convert at a time.
// Reset (asynchronous, active low) clears control and configuration only; table RAM undefined.
module adc_temperature_table_interpolator_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            opcode,
    input  wire logic [atti_pkg::ADC_BITS-1:0]   adc_reading,
    input  wire logic [atti_pkg::IDX_W-1:0]      entry_index,
    input  wire logic [atti_pkg::ADC_BITS-1:0]   entry_adc,
    input  wire logic signed [atti_pkg::TEMP_W-1:0] entry_temp,
    // Output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [atti_pkg::TEMP_W-1:0]   temperature,
    output logic [1:0]                           status,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [atti_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_LAST  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_DIVGO = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int AW = atti_pkg::TBL_AW;
    localparam int AB = atti_pkg::ADC_BITS;
    localparam int TW = atti_pkg::TEMP_W;

    logic [3:0]                  state_reg, state_next;
    logic [AB-1:0]               tol_reg;
    logic [atti_pkg::CNT_W-1:0]  entries_reg;
    logic [AB-1:0]               reading_reg, reading_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [AB-1:0]               prev_adc_reg, prev_adc_next;
    logic signed [TW-1:0]        prev_temp_reg, prev_temp_next;
    logic [AB-1:0]               next_adc_reg, next_adc_next;
    logic signed [TW-1:0]        next_temp_reg, next_temp_next;
    logic signed [atti_pkg::NUM_W-1:0] acc_reg, acc_next;
    logic                        neg_reg, neg_next;
    logic signed [TW-1:0]        res_temp_reg, res_temp_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [TW-1:0]        out_temp_reg, out_temp_next;
    logic [1:0]                  out_status_reg, out_status_next;

    logic                        in_acc;
    logic                        out_free;
    logic                        ram_we;
    logic [AW-1:0]               ram_wa;
    logic [AW-1:0]               ram_ra;
    logic [atti_pkg::ENTRY_W-1:0] ram_wd;
    logic [atti_pkg::ENTRY_W-1:0] ram_rd;
    logic [AB-1:0]               rd_adc;
    logic signed [TW-1:0]        rd_temp;
    logic [AW-1:0]               last_idx;
    logic [AB:0]                 rd_plus_tol;
    logic [AB:0]                 last_plus_tol;
    logic signed [TW-1:0]        mul_a;
    logic signed [atti_pkg::DIFF_W-1:0] mul_b;
    logic signed [atti_pkg::PROD_W-1:0] prod;
    logic [atti_pkg::MAG_W-1:0]  acc_mag;
    logic [atti_pkg::MAG_W-1:0]  quo_signed;
    atti_pkg::div_req_t          div_req;
    atti_pkg::div_rsp_t          div_rsp;

    // Handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= '0;
            entries_reg <= atti_pkg::CNT_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                atti_pkg::CFG_ADC_TOLERANCE:  tol_reg     <= cfg_data[AB-1:0];
                atti_pkg::CFG_ENTRIES_IN_USE: entries_reg <= cfg_data[atti_pkg::CNT_W-1:0];
            endcase
        end
    end

    // Index of the last active entry, entry count clamped to the table
    always_comb
    begin
        priority if (entries_reg < atti_pkg::CNT_W'(2))
            last_idx = AW'(1);
        else if (32'(entries_reg) > atti_pkg::TABLE_DEPTH)
            last_idx = AW'(atti_pkg::TABLE_DEPTH - 1);
        else
            last_idx = AW'(entries_reg - 1'b1);
    end

    // Calibration table
    assign ram_we = in_acc && (opcode == atti_pkg::OP_LOAD)
                    && (32'(entry_index) < atti_pkg::TABLE_DEPTH);
    assign ram_wa = AW'(entry_index);
    assign ram_wd = {entry_adc, entry_temp};

    always_comb
    begin
        unique case (state_reg)
            S_FIRST: ram_ra = last_idx;
            S_LAST:  ram_ra = AW'(1);
            S_SCAN:  ram_ra = idx_reg + 1'b1;
            default: ram_ra = '0;
        endcase
    end

    atti_ram #(
        .WIDTH (atti_pkg::ENTRY_W),
        .DEPTH (atti_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    assign rd_adc  = ram_rd[TW +: AB];
    assign rd_temp = ram_rd[TW-1:0];

    // Band edge sums, one bit wider than the ADC range
    assign rd_plus_tol   = {1'b0, reading_reg} + {1'b0, tol_reg};
    assign last_plus_tol = {1'b0, rd_adc} + {1'b0, tol_reg};

    // Shared multiplier: temperature times ADC distance
    assign mul_a = (state_reg == S_MUL1) ? prev_temp_reg : next_temp_reg;
    assign mul_b = (state_reg == S_MUL1)
                   ? $signed({1'b0, next_adc_reg}) - $signed({1'b0, reading_reg})
                   : $signed({1'b0, reading_reg}) - $signed({1'b0, prev_adc_reg});
    assign prod  = mul_a * mul_b;

    // Divider operands: magnitude of the numerator, positive span
    assign acc_mag = acc_reg[atti_pkg::NUM_W-1]
                     ? atti_pkg::MAG_W'(-acc_reg) : atti_pkg::MAG_W'(acc_reg);
    assign div_req.start    = (state_reg == S_DIVGO);
    assign div_req.dividend = acc_mag;
    assign div_req.divisor  = next_adc_reg - prev_adc_reg;

    atti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Quotient sign restored, truncated toward zero
    assign quo_signed = neg_reg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        reading_next    = reading_reg;
        idx_next        = idx_reg;
        prev_adc_next   = prev_adc_reg;
        prev_temp_next  = prev_temp_reg;
        next_adc_next   = next_adc_reg;
        next_temp_next  = next_temp_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        res_temp_next   = res_temp_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_temp_next   = out_temp_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (opcode == atti_pkg::OP_CONVERT))
                begin
                    reading_next = adc_reading;
                    state_next   = S_FIRST;
                end
            end
            S_FIRST:
            begin
                // First entry: open check, then low clamp
                prev_adc_next  = rd_adc;
                prev_temp_next = rd_temp;
                res_temp_next  = '0;
                res_status_next = atti_pkg::STATUS_OK;
                if (rd_plus_tol < {1'b0, rd_adc})
                begin
                    res_status_next = atti_pkg::STATUS_OPEN;
                    state_next      = S_DONE;
                end
                else if (reading_reg <= rd_adc)
                begin
                    res_temp_next = rd_temp;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // Last entry: short check, then high clamp
                idx_next = AW'(1);
                if ({1'b0, reading_reg} > last_plus_tol)
                begin
                    res_status_next = atti_pkg::STATUS_SHORT;
                    state_next      = S_DONE;
                end
                else if (reading_reg >= rd_adc)
                begin
                    res_temp_next = rd_temp;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Stop at the first entry above the reading, or at the last
                if ((reading_reg < rd_adc) || (idx_reg == last_idx))
                begin
                    next_adc_next  = rd_adc;
                    next_temp_next = rd_temp;
                    state_next     = S_MUL1;
                end
                else
                begin
                    prev_adc_next  = rd_adc;
                    prev_temp_next = rd_temp;
                    idx_next       = idx_reg + 1'b1;
                end
            end
            S_MUL1:
            begin
                acc_next   = atti_pkg::NUM_W'(prod);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = acc_reg + atti_pkg::NUM_W'(prod);
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                neg_next   = acc_reg[atti_pkg::NUM_W-1];
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    res_temp_next = TW'(quo_signed);
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_temp_next   = res_temp_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        reading_reg    <= reading_next;
        idx_reg        <= idx_next;
        prev_adc_reg   <= prev_adc_next;
        prev_temp_reg  <= prev_temp_next;
        next_adc_reg   <= next_adc_next;
        next_temp_reg  <= next_temp_next;
        acc_reg        <= acc_next;
        neg_reg        <= neg_next;
        res_temp_reg   <= res_temp_next;
        res_status_reg <= res_status_next;
        out_temp_reg   <= out_temp_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign temperature = out_temp_reg;
    assign status      = out_status_reg;

endmodule

`default_nettype wire

[design/atti_ram.sv]
`default_nettype none

module atti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[design/atti_div.sv]
`default_nettype none

module atti_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire atti_pkg::div_req_t req,
    output atti_pkg::div_rsp_t      rsp
);

    localparam int DCNT_W = $clog2(atti_pkg::MAG_W + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [DCNT_W-1:0]             cnt_reg, cnt_next;
    logic [atti_pkg::MAG_W-1:0]    quo_reg, quo_next;
    logic [atti_pkg::ADC_BITS-1:0] rem_reg, rem_next;
    logic [atti_pkg::ADC_BITS-1:0] dvs_reg, dvs_next;
    logic [atti_pkg::ADC_BITS:0]   trial;
    logic                          fits;

    // Restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[atti_pkg::MAG_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(atti_pkg::MAG_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? atti_pkg::ADC_BITS'(trial - {1'b0, dvs_reg})
                            : atti_pkg::ADC_BITS'(trial);
            quo_next = {quo_reg[atti_pkg::MAG_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[tb/adc_temperature_table_interpolator_core_test.sv]
`timescale 1ns / 100ps

module adc_temperature_table_interpolator_core_test;

    import atti_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [1:0]               status;
    } reading_result_t;

    // Clock, reset and DUT ports
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic                     opcode      = OP_CONVERT;
    logic [ADC_BITS-1:0]      adc_reading = '0;
    logic [IDX_W-1:0]         entry_index = '0;
    logic [ADC_BITS-1:0]      entry_adc   = '0;
    logic signed [TEMP_W-1:0] entry_temp  = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic signed [TEMP_W-1:0] temperature;
    logic [1:0]               status;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic                     cfg_index   = CFG_ADC_TOLERANCE;
    logic [CFG_DATA_W-1:0]    cfg_data    = '0;

    // Mirror of the calibration table and registers
    logic [ADC_BITS-1:0]      cal_adc  [TABLE_DEPTH];
    logic signed [TEMP_W-1:0] cal_temp [TABLE_DEPTH];
    logic [CFG_DATA_W-1:0]    tolerance_reg = '0;
    logic [CNT_W-1:0]         entries_reg   = CNT_W'(2);

    reading_result_t expected_readings[$];

    int  error_count      = 0;
    int  results_checked  = 0;
    int  loads_sent       = 0;
    int  conversions_sent = 0;
    int  open_predicted   = 0;
    int  short_predicted  = 0;
    int  settings_applied = 0;
    int  stall_left       = 0;
    bit  sender_gaps_on   = 1'b0;
    bit  receiver_stalls_on = 1'b0;

    always #5 clk = ~clk;

    adc_temperature_table_interpolator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .adc_reading (adc_reading),
        .entry_index (entry_index),
        .entry_adc   (entry_adc),
        .entry_temp  (entry_temp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .temperature (temperature),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Entry count as the block uses it: clamped to 2 .. TABLE_DEPTH
    function automatic int active_entries();
        int n;
        n = int'(entries_reg);
        if (n < 2)
            n = 2;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Expected temperature and status for one reading
    function automatic reading_result_t convert_reading(input logic [ADC_BITS-1:0] sample);
        int              n, r, first, last, tol, k;
        longint          a_prev, a_next, num, den, q;
        reading_result_t res;
        n     = active_entries();
        r     = int'(sample);
        first = int'(cal_adc[0]);
        last  = int'(cal_adc[TBL_AW'(n-1)]);
        tol   = int'(tolerance_reg);
        res.temperature = '0;
        res.status      = STATUS_OK;
        // open, low clamp, short, high clamp, then interpolate
        if (r < first - tol)
            res.status = STATUS_OPEN;
        else if (r <= first)
            res.temperature = cal_temp[0];
        else if (r > last + tol)
            res.status = STATUS_SHORT;
        else if (r >= last)
            res.temperature = cal_temp[TBL_AW'(n-1)];
        else
        begin
            // first slot above the reading, paired with the one before it
            k = 1;
            while (k < n - 1 && r >= int'(cal_adc[TBL_AW'(k)]))
                k++;
            a_prev = longint'(cal_adc[TBL_AW'(k-1)]);
            a_next = longint'(cal_adc[TBL_AW'(k)]);
            num = longint'(cal_temp[TBL_AW'(k-1)]) * (a_next - r)
                + longint'(cal_temp[TBL_AW'(k)]) * (r - a_prev);
            den = a_next - a_prev;
            q   = (den > 0) ? num / den : 0;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            res.temperature = q[TEMP_W-1:0];
        end
        return res;
    endfunction

    // Drive one input transaction and predict its effect once accepted
    task automatic submit_sample(input logic op, input logic [ADC_BITS-1:0] rd,
                                 input logic [IDX_W-1:0] idx,
                                 input logic [ADC_BITS-1:0] eadc,
                                 input logic signed [TEMP_W-1:0] etemp);
        reading_result_t want;
        if (sender_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        adc_reading <= rd;
        entry_index <= idx;
        entry_adc   <= eadc;
        entry_temp  <= etemp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            cal_adc[idx]  = eadc;
            cal_temp[idx] = etemp;
            loads_sent++;
        end
        else
        begin
            want = convert_reading(rd);
            expected_readings.push_back(want);
            conversions_sent++;
            if (want.status == STATUS_OPEN)
                open_predicted++;
            if (want.status == STATUS_SHORT)
                short_predicted++;
        end
    endtask

    task automatic load_entry(input int slot, input int adc, input int temp);
        submit_sample(OP_LOAD, ADC_BITS'($urandom), IDX_W'(slot), ADC_BITS'(adc),
                      TEMP_W'(temp));
    endtask

    task automatic convert_sample(input int rd);
        submit_sample(OP_CONVERT, ADC_BITS'(rd), IDX_W'($urandom), ADC_BITS'($urandom),
                      TEMP_W'($urandom));
    endtask

    // Let the block go idle: nothing outstanding, loads given time to land
    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic apply_settings(input int tol, input int count);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ADC_TOLERANCE;
        cfg_data  <= CFG_DATA_W'(tol);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tolerance_reg = CFG_DATA_W'(tol);
        cfg_index <= CFG_ENTRIES_IN_USE;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        entries_reg = CNT_W'(count);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Sorted table with random content in every slot
    task automatic load_sorted_table();
        int marks[$];
        repeat (TABLE_DEPTH)
            marks.push_back($urandom_range(0, 4095));
        marks.sort();
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(i, marks[i], $urandom);
    endtask

    // Reading biased towards the table span and the band edges
    task automatic random_conversion();
        int n, first, last, tol, lo, hi, rd;
        n     = active_entries();
        first = int'(cal_adc[0]);
        last  = int'(cal_adc[TBL_AW'(n-1)]);
        tol   = int'(tolerance_reg);
        case ($urandom_range(0, 7))
            0: rd = $urandom_range(0, 4095);
            1: rd = first - tol + int'($urandom_range(0, 2)) - 1;
            2: rd = last + tol + int'($urandom_range(0, 2)) - 1;
            3: rd = int'(cal_adc[TBL_AW'($urandom_range(0, n - 1))]);
            default:
            begin
                lo = first - tol - 4;
                hi = last + tol + 4;
                if (lo < 0)
                    lo = 0;
                if (hi > 4095)
                    hi = 4095;
                if (lo > 4095)
                    lo = 4095;
                if (hi < 0)
                    hi = 0;
                rd = $urandom_range(lo, hi);
            end
        endcase
        if (rd < 0)
            rd = 0;
        if (rd > 4095)
            rd = 4095;
        convert_sample(rd);
    endtask

    // Fill every slot, sorted, with the extreme temperatures at the ends
    task automatic test_table_load();
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(i, i * 273, (i % 2) ? 32767 - (15 - i) * 50 : -32768 + i * 50);
    endtask

    // Full table, no band: exact ends clamp, interior interpolates
    task automatic test_end_clamps();
        apply_settings(0, 16);
        convert_sample(0);
        convert_sample(4095);
        convert_sample(273);
        convert_sample(2000);
    endtask

    // Open and short on either side of the band edges
    task automatic test_range_errors();
        apply_settings(50, 4);
        load_entry(0, 100, -32768);
        convert_sample(0);
        convert_sample(49);
        convert_sample(50);
        convert_sample(869);
        convert_sample(870);
        convert_sample(4095);
    endtask

    // Widest band over a two entry table
    task automatic test_overlapping_bands();
        apply_settings(4095, 2);
        convert_sample(0);
        convert_sample(200);
        convert_sample(4095);
    endtask

    // Entry counts below 2 and above the table depth
    task automatic test_entry_count_limits();
        apply_settings(0, 0);
        convert_sample(99);
        convert_sample(300);
        apply_settings(0, 31);
        convert_sample(4000);
        convert_sample(4095);
    endtask

    // Random settings and traffic; the last two phases run without sender gaps or output stalls
    task automatic test_random_traffic(input int phases, input int per_phase);
        int tol, count;
        for (int p = 0; p < phases; p++)
        begin
            if (p == 0)
            begin
                tol   = 0;
                count = 16;
            end
            else if (p == 1)
            begin
                tol   = 4095;
                count = 2;
            end
            else
            begin
                tol   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 80);
                count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(2, 16);
            end
            apply_settings(tol, count);
            if (p >= phases - 2)
            begin
                sender_gaps_on     = 1'b0;
                receiver_stalls_on = 1'b0;
            end
            if (p == 0 || $urandom_range(0, 1) == 1)
                load_sorted_table();
            repeat (per_phase)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_entry($urandom_range(0, 15), $urandom_range(0, 4095), $urandom);
                else
                    random_conversion();
            end
        end
    endtask

    // Output stall in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (receiver_stalls_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 16);
        out_stall <= (stall_left > 0);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        reading_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: result with none expected: temperature %0d status %0d",
                         $time, temperature, status);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                results_checked++;
                if (temperature !== want.temperature)
                begin
                    $display("%0t: temperature mismatch: expected %0d, actual %0d",
                             $time, want.temperature, temperature);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung handshake
    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;

        test_table_load();
        test_end_clamps();
        test_range_errors();
        test_overlapping_bands();
        test_entry_count_limits();
        test_random_traffic(12, 100);

        drain_block();
        repeat (100) @(posedge clk);

        $display("Covered %0d table loads and %0d conversions (%0d open, %0d short)",
                 loads_sent, conversions_sent, open_predicted, short_predicted);
        $display("under %0d register settings; checked %0d results, %0d mismatches.",
                 settings_applied, results_checked, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
